// ----- rtl/cpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared constants for the constant power factor reactive dispatch block.
// ----------------------------------------------------------------------------
package cpf_pkg;

  // Configuration registers are 16 bits wide at most.
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PF_SETPOINT   = 3'd0,
    CFG_LAGGING_LIMIT = 3'd1,
    CFG_LEADING_LIMIT = 3'd2,
    CFG_ABSOLUTE_MODE = 3'd3,
    CFG_LAGGING_SEL   = 3'd4
  } cfg_reg_e;

endpackage

// ----- rtl/cpf_req_if.sv -----
// ----------------------------------------------------------------------------
// cpf_req_if
// Request channel: active power demand and reactive capability.
// ----------------------------------------------------------------------------
interface cpf_req_if #(
  parameter int unsigned POWER_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [POWER_WIDTH-1:0] active_demand;
  logic signed [POWER_WIDTH-1:0] reactive_capacity;

  modport source (output valid, output active_demand, output reactive_capacity,
                  input ready);
  modport sink   (input valid, input active_demand, input reactive_capacity,
                  output ready);
endinterface

// ----- rtl/cpf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cpf_rsp_if
// Response channel: reactive command, effective power factor and flag.
// ----------------------------------------------------------------------------
interface cpf_rsp_if #(
  parameter int unsigned POWER_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [POWER_WIDTH-1:0] reactive_demand;
  logic signed [15:0]            effective_pf;
  logic                          pf_control_flag;

  modport source (output valid, output reactive_demand, output effective_pf,
                  output pf_control_flag, input ready);
  modport sink   (input valid, input reactive_demand, input effective_pf,
                  input pf_control_flag, output ready);
endinterface

// ----- rtl/cpf_sqrt_div.sv -----
// ----------------------------------------------------------------------------
// cpf_sqrt_div
// Pipelined integer square root followed by a pipelined divider, one result
// bit per stage: quot = floor(isqrt(x) / a), with an overflow flag when the
// quotient does not fit in POWER_WIDTH bits (also raised for a zero divisor).
// ----------------------------------------------------------------------------
module cpf_sqrt_div #(
  parameter int unsigned POWER_WIDTH  = 24,
  parameter int unsigned PF_FRAC_BITS = 14,
  parameter int unsigned SBW          = 41
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [2*POWER_WIDTH+2*PF_FRAC_BITS:0]         x_i,
  input  logic [PF_FRAC_BITS:0]                         a_i,
  input  logic [SBW-1:0]                                sb_i,
  output logic                                          valid_o,
  output logic [POWER_WIDTH-1:0]                        quot_o,
  output logic                                          ovf_o,
  output logic [SBW-1:0]                                sb_o
);
  localparam int unsigned PW  = POWER_WIDTH;
  localparam int unsigned AW  = PF_FRAC_BITS + 1;
  localparam int unsigned RW  = POWER_WIDTH + PF_FRAC_BITS + 1;
  localparam int unsigned XW  = 2*POWER_WIDTH + 2*PF_FRAC_BITS + 1;
  localparam int unsigned RMW = RW + 2;

  // Square root stages.
  logic                sq_vld_q  [RW];
  logic [2*RW-1:0]     sq_x_q    [RW];
  logic [RMW-1:0]      sq_rem_q  [RW];
  logic [RW-1:0]       sq_root_q [RW];
  logic [AW-1:0]       sq_a_q    [RW];
  logic [SBW-1:0]      sq_sb_q   [RW];

  // Divider stages.
  logic                dv_vld_q  [PW];
  logic [RW-1:0]       dv_rem_q  [PW];
  logic [PW-1:0]       dv_quot_q [PW];
  logic                dv_ovf_q  [PW];
  logic [AW-1:0]       dv_a_q    [PW];
  logic [SBW-1:0]      dv_sb_q   [PW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic              vld_in;
    logic [2*RW-1:0]   x_in;
    logic [RMW-1:0]    rem_in;
    logic [RW-1:0]     root_in;
    logic [AW-1:0]     a_in;
    logic [SBW-1:0]    sb_in;
    logic [RMW+1:0]    rem_sh;
    logic [RMW+1:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign x_in    = {{(2*RW-XW){1'b0}}, x_i};
      assign rem_in  = '0;
      assign root_in = '0;
      assign a_in    = a_i;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign vld_in  = sq_vld_q[k-1];
      assign x_in    = sq_x_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign a_in    = sq_a_q[k-1];
      assign sb_in   = sq_sb_q[k-1];
    end

    assign rem_sh = {rem_in, x_in[2*RW-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_x_q[k]    <= x_in << 2;
        sq_rem_q[k]  <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
        sq_root_q[k] <= {root_in[RW-2:0], ge};
        sq_a_q[k]    <= a_in;
        sq_sb_q[k]   <= sb_in;
      end
    end
  end

  for (genvar j = 0; j < PW; j++) begin : g_div
    localparam int unsigned Bit = PW - 1 - j;
    logic              vld_in;
    logic [RW-1:0]     rem_in;
    logic [PW-1:0]     quot_in;
    logic              ovf_in;
    logic [AW-1:0]     a_in;
    logic [SBW-1:0]    sb_in;
    logic [RW-1:0]     dvs;
    logic              ge;

    if (j == 0) begin : g_first
      assign vld_in  = sq_vld_q[RW-1];
      assign rem_in  = sq_root_q[RW-1];
      assign quot_in = '0;
      // The quotient needs more than PW bits when root >> PW reaches a.
      assign ovf_in  = (sq_root_q[RW-1][RW-1:PW] >= sq_a_q[RW-1]);
      assign a_in    = sq_a_q[RW-1];
      assign sb_in   = sq_sb_q[RW-1];
    end else begin : g_next
      assign vld_in  = dv_vld_q[j-1];
      assign rem_in  = dv_rem_q[j-1];
      assign quot_in = dv_quot_q[j-1];
      assign ovf_in  = dv_ovf_q[j-1];
      assign a_in    = dv_a_q[j-1];
      assign sb_in   = dv_sb_q[j-1];
    end

    assign dvs = RW'(a_in) << Bit;
    assign ge  = (rem_in >= dvs);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[j]  <= ge ? (rem_in - dvs) : rem_in;
        dv_quot_q[j] <= {quot_in[PW-2:0], ge};
        dv_ovf_q[j]  <= ovf_in;
        dv_a_q[j]    <= a_in;
        dv_sb_q[j]   <= sb_in;
      end
    end
  end

  assign valid_o = dv_vld_q[PW-1];
  assign quot_o  = dv_quot_q[PW-1];
  assign ovf_o   = dv_ovf_q[PW-1];
  assign sb_o    = dv_sb_q[PW-1];

endmodule

// ----- rtl/constant_power_factor_var_dispatch.sv -----
// ----------------------------------------------------------------------------
// constant_power_factor_var_dispatch
// Reactive power command for a configured power factor.
// ----------------------------------------------------------------------------
// Requests on req_i carry an active power demand P and the reactive
// capability Qa. Each request yields one response on rsp_o: the signed
// reactive command |P|*sqrt(1/pf^2-1) capped at |Qa| (|Qa| for a zero power
// factor), signed by the direction, plus the clamped power factor in use.
// The configuration port writes one register per cycle; the user must write
// only while the block is idle (not enforced by the block). The registers
// are sampled as each request enters the first stage. The pipeline has
// four front stages (magnitudes, squares, split multiply, sum), one stage
// per root bit of the square root, one per quotient bit of the divider,
// and the output register. A new request is taken every cycle unless the
// output stalls. The whole pipeline advances together: when the response
// waits unread, req_i.ready drops and every stage holds its contents.
// Reset empties the pipeline and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module constant_power_factor_var_dispatch #(
  parameter int unsigned POWER_WIDTH  = 24,
  parameter int unsigned PF_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cpf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cpf_req_if.sink                       req_i,
  cpf_rsp_if.source                     rsp_o
);
  localparam int unsigned PW  = POWER_WIDTH;
  localparam int unsigned F   = PF_FRAC_BITS;
  localparam int unsigned AW  = F + 1;
  localparam int unsigned CW  = (F + 1 > 17) ? F + 1 : 17;
  localparam int unsigned DW  = 2*F + 1;
  localparam int unsigned MW  = PW + DW;
  localparam int unsigned XW  = 2*PW + 2*F + 1;
  localparam int unsigned SBW = PW + 17;
  localparam logic [CW-1:0] OneC = {{(CW-1){1'b0}}, 1'b1} << F;
  localparam logic [DW:0]   OneSq = {{DW{1'b0}}, 1'b1} << (2*F);

  // Configuration registers.
  logic signed [15:0] pf_sp_q, lag_lim_q, lead_lim_q;
  logic               abs_mode_q, lag_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_sp_q    <= 16'sd16384;
      lag_lim_q  <= -16'sd16384;
      lead_lim_q <= 16'sd0;
      abs_mode_q <= 1'b0;
      lag_sel_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cpf_pkg::cfg_reg_e'(cfg_idx_i))
        cpf_pkg::CFG_PF_SETPOINT:   pf_sp_q    <= cfg_wdata_i;
        cpf_pkg::CFG_LAGGING_LIMIT: lag_lim_q  <= cfg_wdata_i;
        cpf_pkg::CFG_LEADING_LIMIT: lead_lim_q <= cfg_wdata_i;
        cpf_pkg::CFG_ABSOLUTE_MODE: abs_mode_q <= cfg_wdata_i[0];
        cpf_pkg::CFG_LAGGING_SEL:   lag_sel_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [CW-1:0] mag16(input logic [15:0] v);
    logic [16:0] m;
    m = v[15] ? ({1'b0, ~v} + 17'd1) : {1'b0, v};
    return CW'(m);
  endfunction

  function automatic logic [PW-1:0] magp(input logic [PW-1:0] v);
    return v[PW-1] ? (~v + PW'(1)) : v;
  endfunction

  // Direction and clamped setpoint magnitude: max(min(|sp|, 1), limit).
  logic          lag_dir;
  logic [CW-1:0] pfa_c, lag_c, lead_c, lim_c, smag_c, s_full;

  always_comb begin
    lag_dir = abs_mode_q ? lag_sel_q : pf_sp_q[15];
    pfa_c   = mag16(pf_sp_q);
    lag_c   = mag16(lag_lim_q);
    lead_c  = mag16(lead_lim_q);
    if (pfa_c  > OneC) pfa_c  = OneC;
    if (lag_c  > OneC) lag_c  = OneC;
    if (lead_c > OneC) lead_c = OneC;
    lim_c   = lag_dir ? lag_c : lead_c;
    smag_c  = (pfa_c > lim_c) ? pfa_c : lim_c;
    s_full  = lag_dir ? (~smag_c + CW'(1)) : smag_c;
  end

  logic en;
  logic out_vld_q;

  assign en          = ~out_vld_q | rsp_o.ready;
  assign req_i.ready = en;

  // Stage A: magnitudes and setpoint.
  logic          a_vld_q;
  logic [PW-1:0] a_p_q;
  logic [AW-1:0] a_s_q;
  logic [SBW-1:0] a_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_p_q  <= magp(req_i.active_demand);
      a_s_q  <= smag_c[AW-1:0];
      a_sb_q <= {lag_dir, magp(req_i.reactive_capacity), s_full[15:0]};
    end
  end

  // Stage B: P squared and 1 - pf squared.
  logic            b_vld_q;
  logic [2*PW-1:0] b_pp_q;
  logic [DW-1:0]   b_d_q;
  logic [AW-1:0]   b_s_q;
  logic [SBW-1:0]  b_sb_q;
  logic [DW:0]     aa;

  assign aa = (DW+1)'(a_s_q) * (DW+1)'(a_s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_pp_q <= (2*PW)'(a_p_q) * (2*PW)'(a_p_q);
      b_d_q  <= DW'(OneSq - aa);
      b_s_q  <= a_s_q;
      b_sb_q <= a_sb_q;
    end
  end

  // Stage C: the wide product in two halves.
  logic           c_vld_q;
  logic [MW-1:0]  c_lo_q, c_hi_q;
  logic [AW-1:0]  c_s_q;
  logic [SBW-1:0] c_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_lo_q <= MW'(b_pp_q[PW-1:0]) * MW'(b_d_q);
      c_hi_q <= MW'(b_pp_q[2*PW-1:PW]) * MW'(b_d_q);
      c_s_q  <= b_s_q;
      c_sb_q <= b_sb_q;
    end
  end

  // Stage D: P^2 * (1 - pf^2).
  logic           d_vld_q;
  logic [XW-1:0]  d_x_q;
  logic [AW-1:0]  d_s_q;
  logic [SBW-1:0] d_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_x_q  <= {c_hi_q, {PW{1'b0}}} + XW'(c_lo_q);
      d_s_q  <= c_s_q;
      d_sb_q <= c_sb_q;
    end
  end

  logic           sd_vld, sd_ovf;
  logic [PW-1:0]  sd_quot;
  logic [SBW-1:0] sd_sb;

  cpf_sqrt_div #(
    .POWER_WIDTH  (POWER_WIDTH),
    .PF_FRAC_BITS (PF_FRAC_BITS),
    .SBW          (SBW)
  ) u_sqrt_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld_q),
    .x_i     (d_x_q),
    .a_i     (d_s_q),
    .sb_i    (d_sb_q),
    .valid_o (sd_vld),
    .quot_o  (sd_quot),
    .ovf_o   (sd_ovf),
    .sb_o    (sd_sb)
  );

  // Output stage: cap, sign and saturate.
  logic          e_lag;
  logic [PW-1:0] e_cap, e_mag, e_cmd;
  localparam logic [PW-1:0] MaxPos = {1'b0, {(PW-1){1'b1}}};

  always_comb begin
    e_lag = sd_sb[SBW-1];
    e_cap = sd_sb[PW+15:16];
    e_mag = (sd_ovf || (sd_quot > e_cap)) ? e_cap : sd_quot;
    if (e_lag) begin
      e_cmd = ~e_mag + PW'(1);
    end else begin
      e_cmd = (e_mag > MaxPos) ? MaxPos : e_mag;
    end
  end

  logic [PW-1:0] out_cmd_q;
  logic [15:0]   out_pf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_cmd_q <= e_cmd;
      out_pf_q  <= sd_sb[15:0];
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.reactive_demand = out_cmd_q;
  assign rsp_o.effective_pf    = out_pf_q;
  assign rsp_o.pf_control_flag = 1'b0;

`ifndef NO_ASSERTIONS
  // A response left unread must stall the request side.
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request accepted while the response is stalled");

  // An accepted request enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> a_vld_q)
    else $error("accepted request lost at the first stage");

  // The capped magnitude never exceeds the capability.
  a_mag_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_vld |-> e_mag <= e_cap)
    else $error("reactive magnitude above capability");
`endif

endmodule

// ----- bench/tb_constant_power_factor_var_dispatch.sv -----
// ----------------------------------------------------------------------------
// tb_constant_power_factor_var_dispatch
// Self-checking bench for the constant power factor reactive dispatch block.
// ----------------------------------------------------------------------------
// Requests of active demand and reactive capability are driven with random
// gaps. The response side stalls at random. Each accepted request is turned
// into an expected reactive command and effective power factor by an
// independent exact-arithmetic predictor, and every response is compared
// with the oldest expectation. The configuration is changed between phases
// once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_constant_power_factor_var_dispatch;

  localparam int unsigned PW       = 24;
  localparam int unsigned FRAC     = 14;
  localparam longint      PF_UNITY = longint'(1) << FRAC;
  localparam int unsigned LATENCY  = 2 * PW + FRAC + 6;
  localparam int unsigned WATCHDOG = 20000;

  typedef struct packed {
    logic signed [PW-1:0] cmd;
    logic signed [15:0]   pf;
    logic                 flag;
  } dispatch_t;

  class var_scoreboard;
    logic signed [15:0] pf_set;
    logic signed [15:0] lag_lim;
    logic signed [15:0] lead_lim;
    bit                 abs_mode;
    bit                 lag_sel;
    dispatch_t          pending[$];
    int                 mismatches;
    int                 checked;

    function void reset_cfg();
      pf_set   = 16'sd16384;
      lag_lim  = -16'sd16384;
      lead_lim = 16'sd0;
      abs_mode = 1'b0;
      lag_sel  = 1'b0;
    endfunction

    // Largest c in [0, cap] with c^2 * s^2 <= p^2 * (1 - s^2), all scaled.
    function longint unsigned reactive_size(longint unsigned p, longint unsigned s,
                                            longint unsigned cap);
      logic [127:0]    lhs;
      logic [127:0]    rhs;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      lhs = 128'(p) * 128'(p) * 128'(PF_UNITY * PF_UNITY - s * s);
      lo  = 0;
      hi  = cap;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        rhs = 128'(mid) * 128'(mid) * 128'(s) * 128'(s);
        if (rhs <= lhs) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function dispatch_t predict(logic signed [PW-1:0] p, logic signed [PW-1:0] q);
      longint          lag;
      longint          lead;
      longint          pfa;
      longint          s;
      longint          pv;
      longint          qv;
      longint unsigned size;
      bit              lagging;
      dispatch_t       r;
      pv   = p;
      qv   = q;
      lag  = lag_lim < 0 ? -longint'(lag_lim) : longint'(lag_lim);
      lead = lead_lim < 0 ? -longint'(lead_lim) : longint'(lead_lim);
      pfa  = pf_set < 0 ? -longint'(pf_set) : longint'(pf_set);
      if (lag > PF_UNITY) lag = PF_UNITY;
      lag = -lag;
      if (lead > PF_UNITY) lead = PF_UNITY;
      lagging = abs_mode ? lag_sel : (pf_set < 0);
      if (lagging) begin
        s = -pfa;
        if (s > lag) s = lag;
        if (s < -PF_UNITY) s = -PF_UNITY;
      end else begin
        s = pfa;
        if (s > PF_UNITY) s = PF_UNITY;
        if (s < lead) s = lead;
      end
      if (qv < 0) qv = -qv;
      if (pv < 0) pv = -pv;
      if (s == 0) size = qv;
      else size = reactive_size(pv, s < 0 ? -s : s, qv);
      if (lagging) r.cmd = PW'(-longint'(size));
      else if (size > (longint'(1) << (PW - 1)) - 1) r.cmd = {1'b0, {(PW-1){1'b1}}};
      else r.cmd = PW'(size);
      r.pf   = 16'(s);
      r.flag = 1'b0;
      return r;
    endfunction

    function void note_request(logic signed [PW-1:0] p, logic signed [PW-1:0] q);
      pending.push_back(predict(p, q));
    endfunction

    function void check_response(dispatch_t got);
      dispatch_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("response with no request outstanding: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: cmd %0d/%0d pf %0d/%0d flag %b/%b (expected/actual)",
                   want.cmd, got.cmd, want.pf, got.pf, want.flag, got.flag);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [cpf_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [cpf_pkg::CfgDataW-1:0] cfg_wdata = '0;

  cpf_req_if #(.POWER_WIDTH(PW)) req ();
  cpf_rsp_if #(.POWER_WIDTH(PW)) rsp ();

  constant_power_factor_var_dispatch #(.POWER_WIDTH(PW), .PF_FRAC_BITS(FRAC)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  var_scoreboard sb = new();
  int  sent;
  int  phases;
  int  idle_cycles;
  int  stall_mode;   // 0: no stalls, 1: short, 2: heavy
  bit  quiet_sender;

  always #5 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.active_demand = '0;
    req.reactive_capacity = '0;
    rsp.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response back-pressure.
  always @(negedge clk_i) begin
    if (stall_mode == 0) rsp.ready <= 1'b1;
    else if (stall_mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
    else rsp.ready <= ($urandom_range(0, 9) < 3);
  end

  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready)
      sb.check_response('{rsp.reactive_demand, rsp.effective_pf, rsp.pf_control_flag});
    if (req.valid && req.ready) begin
      sb.note_request(req.active_demand, req.reactive_capacity);
      sent++;
    end
  end

  // Watchdog on cycles without any accepted request or response.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(logic signed [PW-1:0] p, logic signed [PW-1:0] q);
    int n;
    @(negedge clk_i);
    req.valid = 1'b1;
    req.active_demand = p;
    req.reactive_capacity = q;
    do @(posedge clk_i); while (!req.ready);
    n = gap_len();
    if (n > 0) begin
      @(negedge clk_i);
      req.valid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cpf_pkg::cfg_reg_e idx, logic [cpf_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(logic signed [15:0] pf, logic signed [15:0] lag,
                            logic signed [15:0] lead, bit abs_m, bit sel);
    drain();
    write_reg(cpf_pkg::CFG_PF_SETPOINT, pf);
    write_reg(cpf_pkg::CFG_LAGGING_LIMIT, lag);
    write_reg(cpf_pkg::CFG_LEADING_LIMIT, lead);
    write_reg(cpf_pkg::CFG_ABSOLUTE_MODE, 16'(abs_m));
    write_reg(cpf_pkg::CFG_LAGGING_SEL, 16'(sel));
    sb.pf_set = pf;
    sb.lag_lim = lag;
    sb.lead_lim = lead;
    sb.abs_mode = abs_m;
    sb.lag_sel = sel;
    phases++;
  endtask

  function automatic logic signed [PW-1:0] rand_power();
    case ($urandom_range(0, 3))
      0: return PW'($urandom);
      1: return PW'($signed(17'($urandom)));
      2: return PW'($signed(12'($urandom)));
      default: return $urandom_range(0, 1) ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
    endcase
  endfunction

  function automatic logic signed [15:0] rand_pf();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        stall_mode = $urandom_range(0, 2);
        quiet_sender = ($urandom_range(0, 4) == 0);
      end
      send_request(rand_power(), rand_power());
    end
  endtask

  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  initial begin
    sb.reset_cfg();
    sent = 0;
    phases = 0;
    idle_cycles = 0;
    stall_mode = 0;
    quiet_sender = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults after reset: unity power factor leading, so commands are zero.
    send_request(PMAX, PMAX);
    send_request(PMIN, PMIN);
    send_request('0, '0);

    // Zero power factor gives full capability, including the saturating case.
    set_config(16'sd0, -16'sd16384, 16'sd0, 1'b0, 1'b0);
    send_request(24'sd1000, PMIN);
    send_request(PMAX, PMAX);
    send_request(-24'sd5, 24'sd77);
    // Lagging via absolute mode at zero power factor.
    set_config(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
    send_request(24'sd1, PMIN);
    send_request(PMIN, PMAX);

    // Typical lagging setpoint of 0.8 with a loose lagging limit.
    set_config(-16'sd13107, -16'sd1000, 16'sd0, 1'b0, 1'b0);
    send_request(24'sd10000, PMAX);
    send_request(-24'sd10000, 24'sd100);
    send_request(PMIN, PMAX);
    send_request(PMAX, PMIN);

    // Out-of-range setpoint and limits clamp to unity.
    set_config(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_request(24'sd12345, PMAX);
    send_request(PMIN, PMIN);
    set_config(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b0);
    send_request(24'sd12345, PMAX);
    // Setpoint below the leading limit is raised to it.
    set_config(16'sd100, 16'sd0, 16'sd9000, 1'b0, 1'b0);
    send_request(24'sd54321, PMAX);
    send_request(PMAX, PMIN);
    // Absolute mode overrides the setpoint sign.
    set_config(-16'sd8192, -16'sd16384, 16'sd0, 1'b1, 1'b0);
    send_request(24'sd3000, PMAX);
    set_config(16'sd15000, -16'sd16384, -16'sd20000, 1'b1, 1'b1);
    send_request(24'sd3000, PMAX);
    send_request(PMAX, 24'sd1);

    for (int k = 0; k < 9; k++) begin
      set_config(rand_pf(), rand_pf(), rand_pf(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      random_burst(100);
    end

    stall_mode = 1;
    drain();
    $display("Checked %0d responses for %0d requests over %0d configurations.",
             sb.checked, sent, phases + 1);
    $display("Covered zero and unity power factors, clamped limits and saturation.");
    if (sb.mismatches == 0 && sb.pending.size() == 0 && sb.checked == sent) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
